// ----- hdl/bmft_pkg.sv -----
`timescale 1ns / 1ps

package bmft_pkg;

  // Fixed field widths
  localparam int unsigned SN_W   = 7;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned ADDR_W = 8;
  localparam int unsigned STAT_W = 2;

  // Request kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Flash commands
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ERASE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  // Write data source
  localparam logic SRC_HOST = 1'b0;
  localparam logic SRC_COPY = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_UNMAPPED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_FREE  = 2'd2;

endpackage

// ----- hdl/bmft_if.sv -----
`timescale 1ns / 1ps

// Request channel: one sector read or write per transfer
interface bmft_req_if import bmft_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            kind;
  logic [SN_W-1:0] sector_number;

  modport source (output valid, output kind, output sector_number, input ready);
  modport sink   (input valid, input kind, input sector_number, output ready);
endinterface

// Response channel: one flash command per transfer
interface bmft_rsp_if import bmft_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] flash_address;
  logic              data_source;
  logic [STAT_W-1:0] status;
  logic              last;

  modport source (output valid, output command, output flash_address, output data_source,
                  output status, output last, input ready);
  modport sink   (input valid, input command, input flash_address, input data_source,
                  input status, input last, output ready);
endinterface

// ----- hdl/block_mapped_flash_translation.sv -----
`timescale 1ns / 1ps

// Block-mapped flash translation. Each request transfer reads or writes one logical
// sector; the block answers with a run of flash command transfers, the final one
// flagged last. A request passes the decode state, and a write to a mapped block also
// the page-used lookup state, before its first command. A read, an error, or a write
// into an unused page of a mapped block gives one command. A write to an unmapped block
// scans the block-allocated flags one block per cycle, skipping the spare, before its
// single write command, or a no-free-block error once all blocks are scanned. A write
// to a used page merges the block into the spare block: a read and a write per page,
// then an erase, 2 * PAGES_PER_BLK + 1 commands at one command per cycle while the sink
// accepts. The single page-address unit computes the read and write addresses (block
// times pages plus offset). A new request is taken only once the previous one has
// issued its last command; the output register lets that command wait for the sink
// while the next request is taken. No clearing pass after reset: used-page words carry
// per-block valid bits.
module block_mapped_flash_translation import bmft_pkg::*; #(
  parameter int unsigned PAGES_PER_BLK = 8,
  parameter int unsigned DATA_BLOCKS   = 16,
  parameter int unsigned TOTAL_BLOCKS  = 17
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bmft_req_if.sink    req_i,
  bmft_rsp_if.source  rsp_o
);

  localparam int unsigned OW = $clog2(PAGES_PER_BLK);
  localparam int unsigned LW = $clog2(DATA_BLOCKS);
  localparam int unsigned BW = $clog2(TOTAL_BLOCKS);
  localparam int unsigned CW = $clog2(TOTAL_BLOCKS + 1);
  localparam int unsigned AW = BW + OW;
  localparam int unsigned NSN = 1 << SN_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_PU    = 3'd2;
  localparam logic [2:0] S_MRD   = 3'd3;
  localparam logic [2:0] S_MWR   = 3'd4;
  localparam logic [2:0] S_ERASE = 3'd5;
  localparam logic [2:0] S_SCAN  = 3'd6;

  // Sector number split tables (logical block, page offset)
  logic [SN_W-1:0] lbn_tab [NSN];
  logic [OW-1:0]   off_tab [NSN];

  for (genvar g = 0; g < NSN; g++) begin : g_split
    assign lbn_tab[g] = SN_W'(g / PAGES_PER_BLK);
    assign off_tab[g] = OW'(g % PAGES_PER_BLK);
  end

  logic [2:0]              state_q, state_d;
  logic                    kind_q, kind_d;
  logic [SN_W-1:0]         lbn_q, lbn_d;
  logic [OW-1:0]           off_q, off_d;
  logic [BW-1:0]           oldb_q, oldb_d;
  logic [PAGES_PER_BLK-1:0] oldused_q, oldused_d;
  logic [OW-1:0]           idx_q, idx_d;
  logic [CW-1:0]           scan_q, scan_d;
  logic [BW-1:0]           spare_q, spare_d;
  logic [TOTAL_BLOCKS-1:0] alloc_q, alloc_d;
  logic [DATA_BLOCKS-1:0]  mvalid_q, mvalid_d;

  // Block map memory
  logic [BW-1:0] bm_mem [DATA_BLOCKS];
  logic [BW-1:0] bm_rdata_q;
  logic          bm_re;
  logic [LW-1:0] bm_raddr;
  logic          bm_we;
  logic [BW-1:0] bm_wdata;

  // Page-used store port
  logic                     pu_we;
  logic [BW-1:0]            pu_waddr;
  logic [PAGES_PER_BLK-1:0] pu_wdata;
  logic                     pu_clr;
  logic [BW-1:0]            pu_raddr;
  logic [PAGES_PER_BLK-1:0] pu_rdata;

  // Output register
  logic              ov_q, ov_d;
  logic [CMD_W-1:0]  cmd_q;
  logic [ADDR_W-1:0] addr_q;
  logic              src_q;
  logic [STAT_W-1:0] stat_q;
  logic              last_q;

  logic              out_free;
  logic              emit;
  logic [CMD_W-1:0]  e_cmd;
  logic [ADDR_W-1:0] e_addr;
  logic              e_src;
  logic [STAT_W-1:0] e_stat;
  logic              e_last;

  // Shared page-address unit
  logic [BW-1:0]     au_blk;
  logic [OW-1:0]     au_off;
  logic [AW-1:0]     au_full;
  logic [ADDR_W-1:0] au_addr;

  assign au_full = AW'(au_blk) * AW'(PAGES_PER_BLK) + AW'(au_off);
  assign au_addr = ADDR_W'(au_full);

  logic                     in_range;
  logic                     mapped;
  logic [PAGES_PER_BLK-1:0] bitv;
  logic                     scan_end;
  logic                     scan_hit;

  assign in_range = lbn_q < SN_W'(DATA_BLOCKS);
  assign mapped   = mvalid_q[lbn_q[LW-1:0]];
  assign bitv     = PAGES_PER_BLK'(1) << off_q;
  assign scan_end = scan_q == CW'(TOTAL_BLOCKS);
  assign scan_hit = (scan_q != CW'(spare_q)) && !alloc_q[scan_q[BW-1:0]];

  assign out_free    = !ov_q || rsp_o.ready;
  assign req_i.ready = state_q == S_IDLE;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    lbn_d     = lbn_q;
    off_d     = off_q;
    oldb_d    = oldb_q;
    oldused_d = oldused_q;
    idx_d     = idx_q;
    scan_d    = scan_q;
    spare_d   = spare_q;
    alloc_d   = alloc_q;
    mvalid_d  = mvalid_q;
    emit      = 1'b0;
    e_cmd     = CMD_NONE;
    e_addr    = '0;
    e_src     = SRC_HOST;
    e_stat    = STAT_OK;
    e_last    = 1'b0;
    au_blk    = oldb_q;
    au_off    = off_q;
    bm_re     = 1'b0;
    bm_raddr  = lbn_tab[req_i.sector_number][LW-1:0];
    bm_we     = 1'b0;
    bm_wdata  = spare_q;
    pu_we     = 1'b0;
    pu_waddr  = oldb_q;
    pu_wdata  = pu_rdata | bitv;
    pu_clr    = 1'b0;
    pu_raddr  = bm_rdata_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          kind_d  = req_i.kind;
          lbn_d   = lbn_tab[req_i.sector_number];
          off_d   = off_tab[req_i.sector_number];
          bm_re   = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        au_blk = bm_rdata_q;
        if (!in_range || (kind_q == KIND_READ && !mapped)) begin
          emit   = 1'b1;
          e_stat = STAT_UNMAPPED;
          e_last = 1'b1;
          if (out_free) state_d = S_IDLE;
        end else if (kind_q == KIND_READ) begin
          emit   = 1'b1;
          e_cmd  = CMD_READ;
          e_addr = au_addr;
          e_last = 1'b1;
          if (out_free) state_d = S_IDLE;
        end else if (!mapped) begin
          scan_d  = '0;
          state_d = S_SCAN;
        end else begin
          oldb_d  = bm_rdata_q;
          state_d = S_PU;
        end
      end
      S_PU: begin
        if ((pu_rdata & bitv) == '0) begin
          // Unused page: write in place
          emit   = 1'b1;
          e_cmd  = CMD_WRITE;
          e_addr = au_addr;
          e_last = 1'b1;
          if (out_free) begin
            pu_we   = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          oldused_d = pu_rdata;
          idx_d     = '0;
          state_d   = S_MRD;
        end
      end
      S_MRD: begin
        au_off = idx_q;
        emit   = 1'b1;
        e_cmd  = CMD_READ;
        e_addr = au_addr;
        if (out_free) state_d = S_MWR;
      end
      S_MWR: begin
        au_blk = spare_q;
        au_off = idx_q;
        emit   = 1'b1;
        e_cmd  = CMD_WRITE;
        e_addr = au_addr;
        e_src  = (idx_q == off_q) ? SRC_HOST : SRC_COPY;
        if (out_free) begin
          if (idx_q == OW'(PAGES_PER_BLK - 1)) begin
            state_d = S_ERASE;
          end else begin
            idx_d   = idx_q + OW'(1);
            state_d = S_MRD;
          end
        end
      end
      S_ERASE: begin
        emit   = 1'b1;
        e_cmd  = CMD_ERASE;
        e_addr = ADDR_W'(oldb_q);
        e_last = 1'b1;
        if (out_free) begin
          // Spare takes over the logical block, old block becomes spare
          pu_we            = 1'b1;
          pu_waddr         = spare_q;
          pu_wdata         = oldused_q | bitv;
          pu_clr           = 1'b1;
          bm_we            = 1'b1;
          alloc_d[spare_q] = 1'b1;
          alloc_d[oldb_q]  = 1'b0;
          spare_d          = oldb_q;
          state_d          = S_IDLE;
        end
      end
      S_SCAN: begin
        au_blk = scan_q[BW-1:0];
        if (scan_end) begin
          emit   = 1'b1;
          e_stat = STAT_NO_FREE;
          e_last = 1'b1;
          if (out_free) state_d = S_IDLE;
        end else if (scan_hit) begin
          emit   = 1'b1;
          e_cmd  = CMD_WRITE;
          e_addr = au_addr;
          e_last = 1'b1;
          if (out_free) begin
            // Free blocks always hold no used pages
            pu_we                       = 1'b1;
            pu_waddr                    = scan_q[BW-1:0];
            pu_wdata                    = bitv;
            bm_we                       = 1'b1;
            bm_wdata                    = scan_q[BW-1:0];
            alloc_d[scan_q[BW-1:0]]     = 1'b1;
            mvalid_d[lbn_q[LW-1:0]]     = 1'b1;
            state_d                     = S_IDLE;
          end
        end else begin
          scan_d = scan_q + CW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ov_d = (emit && out_free) ? 1'b1 : (rsp_o.ready ? 1'b0 : ov_q);

  // Block map memory
  always_ff @(posedge clk_i) begin
    if (bm_we) begin
      bm_mem[lbn_q[LW-1:0]] <= bm_wdata;
    end
    if (bm_re) begin
      bm_rdata_q <= bm_mem[bm_raddr];
    end
  end

  bmft_pu_store #(
    .DEPTH (TOTAL_BLOCKS),
    .AW    (BW),
    .DW    (PAGES_PER_BLK)
  ) u_pu_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (pu_we),
    .waddr_i (pu_waddr),
    .wdata_i (pu_wdata),
    .clr_i   (pu_clr),
    .caddr_i (oldb_q),
    .raddr_i (pu_raddr),
    .rdata_o (pu_rdata)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      spare_q  <= BW'(TOTAL_BLOCKS - 1);
      alloc_q  <= '0;
      mvalid_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      spare_q  <= spare_d;
      alloc_q  <= alloc_d;
      mvalid_q <= mvalid_d;
      ov_q     <= ov_d;
    end
  end

  // Request context and output payload
  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    lbn_q     <= lbn_d;
    off_q     <= off_d;
    oldb_q    <= oldb_d;
    oldused_q <= oldused_d;
    idx_q     <= idx_d;
    scan_q    <= scan_d;
    if (emit && out_free) begin
      cmd_q  <= e_cmd;
      addr_q <= e_addr;
      src_q  <= e_src;
      stat_q <= e_stat;
      last_q <= e_last;
    end
  end

  assign rsp_o.valid         = ov_q;
  assign rsp_o.command       = cmd_q;
  assign rsp_o.flash_address = addr_q;
  assign rsp_o.data_source   = src_q;
  assign rsp_o.status        = stat_q;
  assign rsp_o.last          = last_q;

`ifndef NO_ASSERTIONS
  // An accepted request always goes to decode next
  a_accept_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> state_q == S_DEC)
    else $error("request accepted without decode");

  // The spare block is never marked allocated
  a_spare_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !alloc_q[spare_q])
    else $error("spare block marked allocated");

  // An error status comes only with no flash access, and ends the request
  a_err_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && stat_q != STAT_OK |-> cmd_q == CMD_NONE && last_q)
    else $error("error status on a flash command");

  // A merge write is followed by a read of the next page or by the erase
  a_merge_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MWR && out_free |=> state_q == S_MRD || state_q == S_ERASE)
    else $error("merge sequence broken");
`endif

endmodule

// ----- hdl/bmft_pu_store.sv -----
`timescale 1ns / 1ps

// Page-used store: one word of used bits per physical block.
// Registered read, one write and one entry clear per cycle.
// Entries that were never written or were cleared read as zero.
module bmft_pu_store #(
  parameter int unsigned DEPTH = 17,
  parameter int unsigned AW    = 5,
  parameter int unsigned DW    = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          clr_i,
  input  logic [AW-1:0] caddr_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [DEPTH-1:0] vld_d;
  logic [DW-1:0]    rdata_q;
  logic             rvld_q;

  // Data array, no reset
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  // Entry valid bits; a write wins over a clear of the same entry
  always_comb begin
    vld_d = vld_q;
    if (clr_i) begin
      vld_d[caddr_i] = 1'b0;
    end
    if (we_i) begin
      vld_d[waddr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule
